// ===== rtl/core/ccr_pkg.sv =====
// Package with the constants and types shared by the clock replacement cache files.
package ccr_pkg;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned KeyBits   = 64;
  localparam int unsigned ValueBits = 64;
  localparam int unsigned SlotW     = $clog2(Capacity);
  localparam int unsigned CntW      = $clog2(Capacity + 1);
  localparam int unsigned CfgW      = 5;

  localparam logic [CfgW-1:0] ActiveReset = CfgW'(Capacity);

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SWEEP,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic        operation;
    logic [63:0] key;
    logic [63:0] write_value;
  } in_item_t;

  typedef struct packed {
    logic        hit;
    logic [63:0] read_value;
    logic [3:0]  slot;
    logic        replaced;
  } out_item_t;

  typedef struct packed {
    logic                 we;
    logic [SlotW-1:0]     waddr;
    logic [KeyBits-1:0]   wkey;
    logic [ValueBits-1:0] wval;
    logic [SlotW-1:0]     raddr;
  } mem_req_t;

endpackage

// ===== rtl/core/clock_replacement_cache.sv =====
// Top level of the fully associative key/value cache with clock replacement.
// A lookup reads one stored key per cycle from the key memory and compares it, lowest slot
// first, up to the fill count, and skips the scan on an empty cache. A write into a free
// slot goes straight to the result; a write to a full cache moves the clock hand one slot
// per cycle, clearing use marks, until it finds an unmarked slot below n, where n is the
// configured active count limited to the range 1 to 16.
// The block takes a new item only after the previous one has reached the output register,
// which may still hold an earlier result.
module clock_replacement_cache (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ccr_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ccr_pkg::out_item_t         out_item_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [ccr_pkg::CfgW-1:0]   cfg_data_i
);

  logic [ccr_pkg::CfgW-1:0]      active_q, active_d;
  logic [ccr_pkg::CntW-1:0]      eff_cnt;
  ccr_pkg::mem_req_t             mem_req;
  logic [ccr_pkg::KeyBits-1:0]   rd_key;
  logic [ccr_pkg::ValueBits-1:0] rd_val;

  assign cfg_ready_o = 1'b1;
  assign active_d    = (cfg_valid_i) ? cfg_data_i : active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= ccr_pkg::ActiveReset;
    end else begin
      active_q <= active_d;
    end
  end

  always_comb begin
    priority if (active_q == '0) begin
      eff_cnt = ccr_pkg::CntW'(1);
    end else if (ccr_pkg::CntW'(active_q) > ccr_pkg::CntW'(ccr_pkg::Capacity)) begin
      eff_cnt = ccr_pkg::CntW'(ccr_pkg::Capacity);
    end else begin
      eff_cnt = ccr_pkg::CntW'(active_q);
    end
  end

  ccr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_cnt_i   (eff_cnt),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .mem_req_o   (mem_req),
    .rd_key_i    (rd_key),
    .rd_val_i    (rd_val)
  );

  ccr_store u_store (
    .clk_i    (clk_i),
    .req_i    (mem_req),
    .rd_key_o (rd_key),
    .rd_val_o (rd_val)
  );

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("Input was still ready right after an item was accepted.");

  a_write_no_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.replaced |-> !out_item_o.hit)
    else $error("A replacing write reported a hit.");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.hit |-> out_item_o.read_value == '0)
    else $error("A result without a hit carried a nonzero value.");

  a_victim_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req.we && !in_ready_o |-> ccr_pkg::CntW'(mem_req.waddr) < eff_cnt)
    else $error("The clock hand replaced a slot beyond the active count.");

endmodule

// ===== rtl/core/ccr_store.sv =====
// Key and value memories with one write port and one registered read port.
module ccr_store (
  input  logic                          clk_i,
  input  ccr_pkg::mem_req_t             req_i,
  output logic [ccr_pkg::KeyBits-1:0]   rd_key_o,
  output logic [ccr_pkg::ValueBits-1:0] rd_val_o
);

  logic [ccr_pkg::KeyBits-1:0]   key_mem [ccr_pkg::Capacity];
  logic [ccr_pkg::ValueBits-1:0] val_mem [ccr_pkg::Capacity];
  logic [ccr_pkg::KeyBits-1:0]   rd_key_q;
  logic [ccr_pkg::ValueBits-1:0] rd_val_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      key_mem[req_i.waddr] <= req_i.wkey;
      val_mem[req_i.waddr] <= req_i.wval;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= key_mem[req_i.raddr];
    rd_val_q <= val_mem[req_i.raddr];
  end

  assign rd_key_o = rd_key_q;
  assign rd_val_o = rd_val_q;

endmodule

// ===== rtl/core/ccr_ctrl.sv =====
// Sequencer that scans keys, sweeps the clock hand and holds the result register.
module ccr_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [ccr_pkg::CntW-1:0]      eff_cnt_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ccr_pkg::in_item_t             in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ccr_pkg::out_item_t            out_item_o,
  output ccr_pkg::mem_req_t             mem_req_o,
  input  logic [ccr_pkg::KeyBits-1:0]   rd_key_i,
  input  logic [ccr_pkg::ValueBits-1:0] rd_val_i
);

  ccr_pkg::state_e                 state_q, state_d;
  logic [ccr_pkg::KeyBits-1:0]     key_q, key_d;
  logic [ccr_pkg::ValueBits-1:0]   val_q, val_d;
  logic [ccr_pkg::SlotW-1:0]       idx_q, idx_d;
  logic [ccr_pkg::SlotW-1:0]       hand_q, hand_d;
  logic [ccr_pkg::CntW-1:0]        fill_q, fill_d;
  logic [ccr_pkg::Capacity-1:0]    marks_q, marks_d;
  ccr_pkg::out_item_t              res_q, res_d;
  ccr_pkg::out_item_t              out_q, out_d;
  logic                            out_valid_q, out_valid_d;
  logic [ccr_pkg::SlotW-1:0]       hand_adv;
  logic [ccr_pkg::CntW-1:0]        hand_inc;
  logic [ccr_pkg::CntW-1:0]        idx_inc;

  assign hand_inc = ccr_pkg::CntW'(hand_q) + ccr_pkg::CntW'(1);
  assign hand_adv = (hand_inc >= eff_cnt_i) ? '0 : ccr_pkg::SlotW'(hand_inc);
  assign idx_inc  = ccr_pkg::CntW'(idx_q) + ccr_pkg::CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ccr_pkg::ST_IDLE;
      hand_q      <= '0;
      fill_q      <= '0;
      marks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hand_q      <= hand_d;
      fill_q      <= fill_d;
      marks_q     <= marks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
    idx_q <= idx_d;
    res_q <= res_d;
    out_q <= out_d;
  end

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    val_d       = val_q;
    idx_d       = idx_q;
    hand_d      = hand_q;
    fill_d      = fill_q;
    marks_d     = marks_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    in_ready_o  = 1'b0;
    mem_req_o       = '0;
    mem_req_o.raddr = ccr_pkg::SlotW'(idx_inc);

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ccr_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        mem_req_o.raddr = '0;
        if (in_valid_i) begin
          key_d = in_item_i.key[ccr_pkg::KeyBits-1:0];
          val_d = in_item_i.write_value[ccr_pkg::ValueBits-1:0];
          idx_d = '0;
          res_d = '0;
          if (in_item_i.operation == ccr_pkg::OP_LOOKUP) begin
            state_d = (fill_q == '0) ? ccr_pkg::ST_FINISH : ccr_pkg::ST_LOOK;
          end else if (fill_q < eff_cnt_i) begin
            mem_req_o.we    = 1'b1;
            mem_req_o.waddr = ccr_pkg::SlotW'(fill_q);
            mem_req_o.wkey  = in_item_i.key[ccr_pkg::KeyBits-1:0];
            mem_req_o.wval  = in_item_i.write_value[ccr_pkg::ValueBits-1:0];
            marks_d[ccr_pkg::SlotW'(fill_q)] = 1'b1;
            fill_d     = fill_q + ccr_pkg::CntW'(1);
            res_d.slot = 4'(fill_q);
            state_d    = ccr_pkg::ST_FINISH;
          end else begin
            if (ccr_pkg::CntW'(hand_q) >= eff_cnt_i) begin
              hand_d = '0;
            end
            state_d = ccr_pkg::ST_SWEEP;
          end
        end
      end
      ccr_pkg::ST_LOOK: begin
        if (rd_key_i == key_q) begin
          res_d.hit        = 1'b1;
          res_d.read_value = 64'(rd_val_i);
          res_d.slot       = 4'(idx_q);
          marks_d[idx_q]   = 1'b1;
          state_d          = ccr_pkg::ST_FINISH;
        end else if (idx_inc >= fill_q) begin
          state_d = ccr_pkg::ST_FINISH;
        end else begin
          idx_d = ccr_pkg::SlotW'(idx_inc);
        end
      end
      ccr_pkg::ST_SWEEP: begin
        hand_d = hand_adv;
        if (marks_q[hand_q]) begin
          marks_d[hand_q] = 1'b0;
        end else begin
          mem_req_o.we    = 1'b1;
          mem_req_o.waddr = hand_q;
          mem_req_o.wkey  = key_q;
          mem_req_o.wval  = val_q;
          marks_d[hand_q] = 1'b1;
          res_d.slot      = 4'(hand_q);
          res_d.replaced  = 1'b1;
          state_d         = ccr_pkg::ST_FINISH;
        end
      end
      ccr_pkg::ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ccr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ccr_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== test/clock_replacement_cache_tb.sv =====
// Testbench for the clock replacement cache with a directed table and random checked items.
`timescale 1ns / 100ps

module clock_replacement_cache_tb;

  localparam int RESET_CYCLES    = 5;
  localparam int MAX_IDLE        = 13;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int NUM_DIR         = 23;
  localparam int NUM_PHASES      = 12;
  localparam int ITEMS_PER_PHASE = 42;
  localparam int KEY_POOL        = 24;
  localparam logic [63:0] ALL_ONES = '1;

  typedef struct {
    logic                     is_cfg;
    logic [ccr_pkg::CfgW-1:0] cfg;
    ccr_pkg::in_item_t        item;
    logic                     typed;
    ccr_pkg::out_item_t       result;
  } dir_row_t;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_ready;
  ccr_pkg::in_item_t        in_item   = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  ccr_pkg::out_item_t       out_item;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [ccr_pkg::CfgW-1:0] cfg_data  = '0;

  logic                     in_idle_on  = 1'b1;
  logic                     out_idle_on = 1'b1;
  int                       errors      = 0;
  int                       cycle_count = 0;
  ccr_pkg::out_item_t       due_results [$];

  logic [63:0]              shadow_key   [ccr_pkg::Capacity];
  logic [63:0]              shadow_value [ccr_pkg::Capacity];
  logic                     shadow_mark  [ccr_pkg::Capacity];
  int                       shadow_fill;
  int                       shadow_hand;
  logic [ccr_pkg::CfgW-1:0] shadow_active;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, 64'h0, 64'h0}, 1'b1,
      '{1'b0, 64'h0, 4'd0, 1'b0}},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h0, ALL_ONES}, 1'b1,
      '{1'b0, 64'h0, 4'd0, 1'b0}},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, ALL_ONES, 64'h0}, 1'b1,
      '{1'b0, 64'h0, 4'd1, 1'b0}},
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, ALL_ONES, 64'h0}, 1'b1,
      '{1'b1, 64'h0, 4'd1, 1'b0}},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h0, 64'h5A5A_5A5A_5A5A_5A5A}, 1'b1,
      '{1'b0, 64'h0, 4'd2, 1'b0}},
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, 64'h0, ALL_ONES}, 1'b1,
      '{1'b1, ALL_ONES, 4'd0, 1'b0}},
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, 64'h8000_0000_0000_0001, 64'h0}, 1'b1,
      '{1'b0, 64'h0, 4'd0, 1'b0}},
    '{1'b0, 5'd0,
      '{ccr_pkg::OP_WRITE, 64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, 1'b1,
      '{1'b0, 64'h0, 4'd3, 1'b0}},
    '{1'b1, 5'd0, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h1, 64'h1}, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, 64'h0, 64'h0}, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h2, 64'h2}, 1'b0, '0},
    '{1'b1, 5'd31, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h3, 64'h3}, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, 64'h3, 64'h0}, 1'b0, '0},
    '{1'b1, 5'd2, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h4, 64'h4}, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h5, 64'h5}, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h6, 64'h6}, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_LOOKUP, ALL_ONES, 64'h0}, 1'b0, '0},
    '{1'b1, 5'd17, '0, 1'b0, '0},
    '{1'b0, 5'd0, '{ccr_pkg::OP_WRITE, 64'h7, 64'h7}, 1'b0, '0},
    '{1'b1, 5'd16, '0, 1'b0, '0}
  };

  logic [ccr_pkg::CfgW-1:0] phase_cfg [8] =
    '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd12, 5'd3, 5'd17};

  clock_replacement_cache u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int next_hand(int hand, int n);
    return (hand + 1 >= n) ? 0 : hand + 1;
  endfunction

  function automatic ccr_pkg::out_item_t predict_access(ccr_pkg::in_item_t it);
    ccr_pkg::out_item_t r;
    int n;
    int idx;
    r = '0;
    if (it.operation == ccr_pkg::OP_LOOKUP) begin
      for (int i = 0; i < shadow_fill; i++) begin
        if (shadow_key[i] == it.key) begin
          r.hit = 1'b1;
          r.read_value = shadow_value[i];
          r.slot = 4'(i);
          shadow_mark[i] = 1'b1;
          break;
        end
      end
    end else begin
      n = (shadow_active == 0) ? 1 :
          (shadow_active > ccr_pkg::Capacity) ? int'(ccr_pkg::Capacity)
                                               : int'(shadow_active);
      if (shadow_fill >= n) begin
        if (shadow_hand >= n) begin
          shadow_hand = 0;
        end
        for (int g = 0; g <= n && shadow_mark[shadow_hand]; g++) begin
          shadow_mark[shadow_hand] = 1'b0;
          shadow_hand = next_hand(shadow_hand, n);
        end
        idx = shadow_hand;
        shadow_hand = next_hand(shadow_hand, n);
        r.replaced = 1'b1;
      end else begin
        idx = shadow_fill;
        shadow_fill++;
      end
      shadow_key[idx] = it.key;
      shadow_value[idx] = it.write_value;
      shadow_mark[idx] = 1'b1;
      r.slot = 4'(idx);
    end
    return r;
  endfunction

  task automatic report(string msg);
    errors++;
    $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic send_item(ccr_pkg::in_item_t it, logic typed,
                           ccr_pkg::out_item_t typed_result);
    int gap;
    ccr_pkg::out_item_t predicted;
    gap = in_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (!in_ready);
    predicted = predict_access(it);
    due_results.push_back(typed ? typed_result : predicted);
  endtask

  task automatic write_config(logic [ccr_pkg::CfgW-1:0] value);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk_i); while (!cfg_ready);
    shadow_active = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  always @(posedge clk_i) begin : check_results
    ccr_pkg::out_item_t want;
    if (rst_ni && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report("result arrived with no item outstanding");
      end else begin
        want = due_results.pop_front();
        if (out_item.hit !== want.hit) begin
          report($sformatf("hit %0b, expected %0b", out_item.hit, want.hit));
        end
        if (out_item.read_value !== want.read_value) begin
          report($sformatf("read_value %0h, expected %0h", out_item.read_value,
                           want.read_value));
        end
        if (out_item.slot !== want.slot) begin
          report($sformatf("slot %0d, expected %0d", out_item.slot, want.slot));
        end
        if (out_item.replaced !== want.replaced) begin
          report($sformatf("replaced %0b, expected %0b", out_item.replaced, want.replaced));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("clock_replacement_cache test failed");
      $finish;
    end
  end

  initial begin : result_sink
    int stall;
    @(posedge rst_ni);
    forever begin
      stall = out_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
    end
  end

  initial begin : stimulus
    logic [63:0] key_pool [KEY_POOL];
    ccr_pkg::in_item_t it;
    logic [ccr_pkg::CfgW-1:0] cfg;
    shadow_active = ccr_pkg::ActiveReset;
    shadow_fill = 0;
    shadow_hand = 0;
    for (int i = 0; i < ccr_pkg::Capacity; i++) begin
      shadow_mark[i] = 1'b0;
    end
    key_pool[0] = 64'h0;
    key_pool[1] = ALL_ONES;
    for (int i = 2; i < KEY_POOL; i++) begin
      key_pool[i] = {$urandom, $urandom};
    end
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      if (dir_rows[r].is_cfg) begin
        write_config(dir_rows[r].cfg);
      end else begin
        send_item(dir_rows[r].item, dir_rows[r].typed, dir_rows[r].result);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      in_idle_on = ($urandom_range(0, 3) != 0);
      out_idle_on = ($urandom_range(0, 3) != 0);
      cfg = (p < 8) ? phase_cfg[p] : ccr_pkg::CfgW'($urandom_range(0, 31));
      write_config(cfg);
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        it.operation = ($urandom_range(0, 9) < 4) ? ccr_pkg::OP_WRITE : ccr_pkg::OP_LOOKUP;
        it.key = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                               : key_pool[$urandom_range(0, KEY_POOL - 1)];
        it.write_value = {$urandom, $urandom};
        send_item(it, 1'b0, '0);
      end
    end

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("clock_replacement_cache test passed");
    end else begin
      $display("clock_replacement_cache test failed");
    end
    $finish;
  end

endmodule
